FILE: hw/rtl/dpc_pkg.sv
// Shared constants and types for the drive distance PI controller.
// Used by the shared multiplier and the top level.
package dpc_pkg;

   localparam int ENC_W  = 32;           // encoder count width
   localparam int ERR_W  = ENC_W + 2;    // position error width
   localparam int INT_W  = 40;           // integrator width, Q32.8
   localparam int RND_W  = INT_W + 1;    // decayed integrator after rounding
   localparam int ISUM_W = INT_W + 3;    // integrator update before saturation
   localparam int ACC_W  = 60;           // PI sum width, Q.24
   localparam int POW_W  = 32;           // clamped power, Q.24
   localparam int FIN_W  = POW_W + 1;    // power after heading correction
   localparam int TRN_W  = 41;           // raw heading term
   localparam int TLM_W  = 31;           // heading term limit
   localparam int MAG_W  = 7;            // mean power magnitude
   localparam int LIM_W  = 17;           // watchdog limit width

   localparam int MA_W = 41;             // multiplier operand A, signed
   localparam int MB_W = 24;             // multiplier operand B, signed
   localparam int MP_W = MA_W + MB_W;    // product

   localparam logic signed [ACC_W-1:0] POWER_LIM   = ACC_W'(70) <<< 24;
   localparam logic [MB_W-1:0]         TLIM_RECIP  = MB_W'((64'd1 << 25) / 5);
   localparam logic [LIM_W-1:0]        LIMIT_MAX   = '1;

   // configuration register indexes
   localparam logic [2:0] CSR_GAIN_PROP      = 3'd0;
   localparam logic [2:0] CSR_GAIN_INTEGRAL  = 3'd1;
   localparam logic [2:0] CSR_INTEGRAL_DECAY = 3'd2;
   localparam logic [2:0] CSR_GAIN_HEADING   = 3'd3;
   localparam logic [2:0] CSR_WATCHDOG_RATE  = 3'd4;
   localparam logic [2:0] CSR_WATCHDOG_BASE  = 3'd5;
   localparam logic [2:0] CSR_SETTLE_ERROR   = 3'd6;
   localparam logic [2:0] CSR_SETTLE_TIME    = 3'd7;

   // request kinds
   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic signed [MA_W-1:0] a;
      logic signed [MB_W-1:0] b;
   } mul_op_type;

endpackage

FILE: hw/rtl/dpc_if.sv
// Request and response channel interfaces of the drive distance PI controller.
// Plain valid/ready handshake; no package dependency.
interface dpc_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] target_count;
   logic signed [31:0] encoder_left;
   logic signed [31:0] encoder_right;
   logic signed [15:0] heading_now;
   logic        [31:0] time_ms;
   modport source (output valid, kind, target_count, encoder_left, encoder_right,
                   heading_now, time_ms, input ready);
   modport sink (input valid, kind, target_count, encoder_left, encoder_right,
                 heading_now, time_ms, output ready);
endinterface

interface dpc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] power_left;
   logic signed [7:0] power_right;
   logic              done_res;
   logic              success;
   modport source (output valid, power_left, power_right, done_res, success,
                   input ready);
   modport sink (input valid, power_left, power_right, done_res, success,
                 output ready);
endinterface

FILE: hw/rtl/dpc_mul.sv
// Shared signed multiplier with registered product.
// Depends on dpc_pkg for operand widths and the operand struct.
module dpc_mul
   import dpc_pkg::*;
(
   input  logic                   clock,
   input  mul_op_type             op,
   output logic signed [MP_W-1:0] prod_ff
);

   logic signed [MP_W-1:0] prod_in;

   assign prod_in = MP_W'(op.a) * MP_W'(op.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: hw/rtl/drive_distance_pi_controller_top.sv
// Drive distance PI controller: one request at a time through a sequencer
// that drives one shared 41x24 multiplier. A start request goes through
// START and LIM to EMIT, a sample during a move through ERR to FIN and then
// EMIT (the six multiplies of the two PI loops, the heading term and the turn
// limit each go through the one multiplier), and a sample while idle straight
// to EMIT. Ready returns with the result, so the next request can then be
// accepted. A held response delays the next request.
// Depends on dpc_pkg, dpc_if and dpc_mul.
module drive_distance_pi_controller_top
   import dpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dpc_req_if.sink     req_chan,
   dpc_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_LIM   = 4'd2;
   localparam logic [3:0] S_ERR   = 4'd3;
   localparam logic [3:0] S_IL    = 4'd4;
   localparam logic [3:0] S_KL    = 4'd5;
   localparam logic [3:0] S_PL    = 4'd6;
   localparam logic [3:0] S_IR    = 4'd7;
   localparam logic [3:0] S_KR    = 4'd8;
   localparam logic [3:0] S_PR    = 4'd9;
   localparam logic [3:0] S_MEAN  = 4'd10;
   localparam logic [3:0] S_TLIM  = 4'd11;
   localparam logic [3:0] S_TURN  = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;
   localparam logic [3:0] S_EMIT  = 4'd14;

   // configuration
   logic [15:0] kp_ff, ki_ff, decay_ff, rate_ff, base_ff, serr_ff, stime_ff;
   logic [11:0] kh_ff;

   // control
   logic [3:0] state_ff, state_in;
   logic       move_active_ff, move_active_in;
   logic       settling_ff, settling_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // captured request
   logic signed [15:0]      in_target_ff;
   logic        [31:0]      in_encl_ff, in_encr_ff, in_time_ff;
   logic signed [15:0]      in_head_ff;

   // move state
   logic signed [15:0]      target_ff, target_in;
   logic [ENC_W-1:0]        lorg_ff, lorg_in, rorg_ff, rorg_in;
   logic signed [15:0]      horg_ff, horg_in;
   logic signed [INT_W-1:0] integ_l_ff, integ_l_in, integ_r_ff, integ_r_in;
   logic [31:0]             mstart_ff, mstart_in, sstart_ff, sstart_in;
   logic [LIM_W-1:0]        limit_ff, limit_in;

   // work registers
   logic signed [ERR_W-1:0] err_l_ff, err_l_in, err_r_ff, err_r_in;
   logic signed [16:0]      hdiff_ff, hdiff_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [POW_W-1:0] pl_ff, pl_in, pr_ff, pr_in;
   logic [MAG_W-1:0]        mean_ff, mean_in;
   logic signed [TRN_W-1:0] turn_ff, turn_in;
   logic signed [TLM_W-1:0] turnc_ff, turnc_in;

   // pending and presented result
   logic signed [7:0] res_pl_ff, res_pl_in, res_pr_ff, res_pr_in;
   logic              res_done_ff, res_done_in, res_ok_ff, res_ok_in;
   logic signed [7:0] out_pl_ff, out_pl_in, out_pr_ff, out_pr_in;
   logic              out_done_ff, out_done_in, out_ok_ff, out_ok_in;

   mul_op_type             mop;
   logic signed [MP_W-1:0] prod_ff;

   dpc_mul u_mul (
      .clock   (clock),
      .op      (mop),
      .prod_ff (prod_ff)
   );

   logic req_acc;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc = req_chan.valid && req_chan.ready;

   // ---------------- datapath helpers ----------------
   logic [ENC_W-1:0]        d_l, d_r;
   logic signed [ERR_W-1:0] err_l_c, err_r_c, err_sel;
   logic signed [INT_W-1:0] integ_sel;
   logic [MP_W-1:0]         pmag;
   logic [INT_W-1:0]        rmag;
   logic signed [RND_W-1:0] rnd;
   logic signed [ISUM_W-1:0] isum;
   logic signed [INT_W-1:0] isat;
   logic signed [ACC_W-1:0] psum;
   logic signed [POW_W-1:0] psat;
   logic signed [FIN_W-1:0] msum;
   logic [FIN_W-1:0]        msum_mag;
   logic [16:0]             tmag;
   logic [17:0]             corr_w;
   logic signed [TLM_W-1:0] tlim;
   logic signed [FIN_W-1:0] plf, prf;
   logic [FIN_W-1:0]        plf_mag, prf_mag;
   logic [8:0]              plt, prt;
   logic [ERR_W-1:0]        eml, emr;
   logic                    settled, done_ok, done_fail;
   logic [31:0]             sstart_c;
   logic [31:0]             rawlim;
   logic [22:0]             limsum;

   assign d_l = in_encl_ff[ENC_W-1:0] - lorg_ff;
   assign d_r = in_encr_ff[ENC_W-1:0] - rorg_ff;
   assign err_l_c = -ERR_W'($signed(d_l)) - ERR_W'(target_ff);
   assign err_r_c = ERR_W'($signed(d_r)) - ERR_W'(target_ff);

   assign err_sel   = (state_ff == S_IL) ? err_l_ff : err_r_ff;
   assign integ_sel = (state_ff == S_KL) ? integ_l_ff : integ_r_ff;

   // decayed integrator, halves rounded away from zero
   assign pmag = prod_ff[MP_W-1] ? (~prod_ff + 1'b1) : prod_ff;
   assign rmag = INT_W'((pmag + MP_W'(32768)) >> 16);
   assign rnd  = prod_ff[MP_W-1] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
   assign isum = ISUM_W'(rnd) + ISUM_W'($signed({err_sel, 8'b0}));

   always_comb begin
      if (isum > $signed(ISUM_W'({1'b0, {(INT_W-1){1'b1}}}))) begin
         isat = {1'b0, {(INT_W-1){1'b1}}};
      end else if (isum < -$signed(ISUM_W'({1'b0, {(INT_W-1){1'b1}}})) - 1) begin
         isat = {1'b1, {(INT_W-1){1'b0}}};
      end else begin
         isat = isum[INT_W-1:0];
      end
   end

   assign psum = acc_ff + ACC_W'(prod_ff);

   always_comb begin
      if (psum > POWER_LIM) begin
         psat = POW_W'(POWER_LIM);
      end else if (psum < -POWER_LIM) begin
         psat = POW_W'(-POWER_LIM);
      end else begin
         psat = psum[POW_W-1:0];
      end
   end

   assign msum     = FIN_W'(pl_ff) + FIN_W'(pr_ff);
   assign msum_mag = msum[FIN_W-1] ? FIN_W'(-msum) : FIN_W'(msum);

   assign tmag = in_target_ff[15] ? 17'(-17'(in_target_ff)) : 17'(in_target_ff);

   // floor(mean * 2^25 / 5) = mean * floor(2^25/5) + floor(2 * mean / 5)
   assign corr_w = 18'({mean_ff, 1'b0}) * 18'd205;
   assign tlim   = TLM_W'(prod_ff[29:0]) + TLM_W'(corr_w[17:10]);

   assign plf     = FIN_W'(pl_ff) - FIN_W'(turnc_ff);
   assign prf     = FIN_W'(pr_ff) + FIN_W'(turnc_ff);
   assign plf_mag = plf[FIN_W-1] ? FIN_W'(-plf) : FIN_W'(plf);
   assign prf_mag = prf[FIN_W-1] ? FIN_W'(-prf) : FIN_W'(prf);
   assign plt     = 9'(plf_mag >> 24);
   assign prt     = 9'(prf_mag >> 24);

   assign eml      = err_l_ff[ERR_W-1] ? ERR_W'(-err_l_ff) : ERR_W'(err_l_ff);
   assign emr      = err_r_ff[ERR_W-1] ? ERR_W'(-err_r_ff) : ERR_W'(err_r_ff);
   assign settled  = (eml < ERR_W'(serr_ff)) && (emr < ERR_W'(serr_ff));
   assign sstart_c = (settled && !settling_ff) ? in_time_ff : sstart_ff;
   assign done_ok  = settled && ((in_time_ff - sstart_c) > 32'(stime_ff));
   assign done_fail = !settled && ((in_time_ff - mstart_ff) > 32'(limit_ff));

   assign rawlim = prod_ff[31:0] + 32'd2048;
   assign limsum = 23'(rawlim >> 12) + 23'(base_ff);

   // ---------------- multiplier operand select ----------------
   always_comb begin
      mop.a = '0;
      mop.b = '0;
      unique case (state_ff)
         S_START: begin
            mop.a = MA_W'($signed({1'b0, tmag}));
            mop.b = MB_W'($signed({1'b0, rate_ff}));
         end
         S_ERR: begin
            mop.a = MA_W'(integ_l_ff);
            mop.b = MB_W'($signed({1'b0, decay_ff}));
         end
         S_PL: begin
            mop.a = MA_W'(integ_r_ff);
            mop.b = MB_W'($signed({1'b0, decay_ff}));
         end
         S_IL, S_IR: begin
            mop.a = MA_W'(err_sel);
            mop.b = MB_W'($signed({1'b0, kp_ff}));
         end
         S_KL, S_KR: begin
            mop.a = MA_W'(integ_sel);
            mop.b = MB_W'($signed({1'b0, ki_ff}));
         end
         S_PR: begin
            mop.a = MA_W'(hdiff_ff);
            mop.b = MB_W'($signed({1'b0, kh_ff}));
         end
         S_TLIM: begin
            mop.a = MA_W'($signed({1'b0, mean_ff}));
            mop.b = $signed(TLIM_RECIP);
         end
         default: begin
            mop.a = '0;
            mop.b = '0;
         end
      endcase
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in       = state_ff;
      move_active_in = move_active_ff;
      settling_in    = settling_ff;
      target_in      = target_ff;
      lorg_in        = lorg_ff;
      rorg_in        = rorg_ff;
      horg_in        = horg_ff;
      integ_l_in     = integ_l_ff;
      integ_r_in     = integ_r_ff;
      mstart_in      = mstart_ff;
      sstart_in      = sstart_ff;
      limit_in       = limit_ff;
      err_l_in       = err_l_ff;
      err_r_in       = err_r_ff;
      hdiff_in       = hdiff_ff;
      acc_in         = acc_ff;
      pl_in          = pl_ff;
      pr_in          = pr_ff;
      mean_in        = mean_ff;
      turn_in        = turn_ff;
      turnc_in       = turnc_ff;
      res_pl_in      = res_pl_ff;
      res_pr_in      = res_pr_ff;
      res_done_in    = res_done_ff;
      res_ok_in      = res_ok_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      out_pl_in      = out_pl_ff;
      out_pr_in      = out_pr_ff;
      out_done_in    = out_done_ff;
      out_ok_in      = out_ok_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               priority if (req_chan.kind == KIND_START) begin
                  state_in = S_START;
               end else if (move_active_ff) begin
                  state_in = S_ERR;
               end else begin
                  // idle sample: zero result, no state change
                  res_pl_in   = '0;
                  res_pr_in   = '0;
                  res_done_in = 1'b0;
                  res_ok_in   = 1'b0;
                  state_in    = S_EMIT;
               end
            end
         end
         S_START: state_in = S_LIM;
         S_LIM: begin
            target_in      = in_target_ff;
            lorg_in        = in_encl_ff[ENC_W-1:0];
            rorg_in        = in_encr_ff[ENC_W-1:0];
            horg_in        = in_head_ff;
            mstart_in      = in_time_ff;
            sstart_in      = in_time_ff;
            integ_l_in     = '0;
            integ_r_in     = '0;
            settling_in    = 1'b0;
            move_active_in = 1'b1;
            limit_in       = (limsum > 23'(LIMIT_MAX)) ? LIMIT_MAX : limsum[LIM_W-1:0];
            res_pl_in      = '0;
            res_pr_in      = '0;
            res_done_in    = 1'b0;
            res_ok_in      = 1'b0;
            state_in       = S_EMIT;
         end
         S_ERR: begin
            err_l_in = err_l_c;
            err_r_in = err_r_c;
            hdiff_in = 17'(horg_ff) - 17'(in_head_ff);
            state_in = S_IL;
         end
         S_IL: begin
            integ_l_in = isat;
            state_in   = S_KL;
         end
         S_KL: begin
            acc_in   = ACC_W'(prod_ff) <<< 8;
            state_in = S_PL;
         end
         S_PL: begin
            pl_in    = psat;
            state_in = S_IR;
         end
         S_IR: begin
            integ_r_in = isat;
            state_in   = S_KR;
         end
         S_KR: begin
            acc_in   = ACC_W'(prod_ff) <<< 8;
            state_in = S_PR;
         end
         S_PR: begin
            pr_in    = psat;
            state_in = S_MEAN;
         end
         S_MEAN: begin
            mean_in  = MAG_W'((msum_mag + FIN_W'(33'd1 << 24)) >> 25);
            turn_in  = TRN_W'(prod_ff) <<< 12;
            state_in = S_TLIM;
         end
         S_TLIM: state_in = S_TURN;
         S_TURN: begin
            // clamp to the mean-power bound, flip for reverse moves
            priority if (turn_ff > TRN_W'(tlim)) begin
               turnc_in = tlim;
            end else if (turn_ff < -TRN_W'(tlim)) begin
               turnc_in = -tlim;
            end else begin
               turnc_in = turn_ff[TLM_W-1:0];
            end
            if (target_ff[15]) begin
               turnc_in = -turnc_in;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            settling_in = settled;
            sstart_in   = sstart_c;
            res_done_in = done_ok || done_fail;
            res_ok_in   = done_ok;
            if (done_ok || done_fail) begin
               move_active_in = 1'b0;
               res_pl_in      = '0;
               res_pr_in      = '0;
            end else begin
               res_pl_in = plf[FIN_W-1] ? -$signed(8'(plt)) : $signed(8'(plt));
               res_pr_in = prf[FIN_W-1] ? -$signed(8'(prt)) : $signed(8'(prt));
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_pl_in    = res_pl_ff;
               out_pr_in    = res_pr_ff;
               out_done_in  = res_done_ff;
               out_ok_in    = res_ok_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= 16'd872;
         ki_ff    <= 16'd308;
         decay_ff <= 16'd59638;
         kh_ff    <= 12'd1306;
         rate_ff  <= 16'd7111;
         base_ff  <= 16'd2000;
         serr_ff  <= 16'd200;
         stime_ff <= 16'd750;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_PROP:      kp_ff    <= csr_wdata;
            CSR_GAIN_INTEGRAL:  ki_ff    <= csr_wdata;
            CSR_INTEGRAL_DECAY: decay_ff <= csr_wdata;
            CSR_GAIN_HEADING:   kh_ff    <= csr_wdata[11:0];
            CSR_WATCHDOG_RATE:  rate_ff  <= csr_wdata;
            CSR_WATCHDOG_BASE:  base_ff  <= csr_wdata;
            CSR_SETTLE_ERROR:   serr_ff  <= csr_wdata;
            CSR_SETTLE_TIME:    stime_ff <= csr_wdata;
            default:            kp_ff    <= kp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         move_active_ff <= 1'b0;
         settling_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         target_ff      <= '0;
         lorg_ff        <= '0;
         rorg_ff        <= '0;
         horg_ff        <= '0;
         integ_l_ff     <= '0;
         integ_r_ff     <= '0;
         mstart_ff      <= '0;
         sstart_ff      <= '0;
         limit_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         move_active_ff <= move_active_in;
         settling_ff    <= settling_in;
         rsp_valid_ff   <= rsp_valid_in;
         target_ff      <= target_in;
         lorg_ff        <= lorg_in;
         rorg_ff        <= rorg_in;
         horg_ff        <= horg_in;
         integ_l_ff     <= integ_l_in;
         integ_r_ff     <= integ_r_in;
         mstart_ff      <= mstart_in;
         sstart_ff      <= sstart_in;
         limit_ff       <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_target_ff <= req_chan.target_count;
         in_encl_ff   <= req_chan.encoder_left;
         in_encr_ff   <= req_chan.encoder_right;
         in_head_ff   <= req_chan.heading_now;
         in_time_ff   <= req_chan.time_ms;
      end
      err_l_ff    <= err_l_in;
      err_r_ff    <= err_r_in;
      hdiff_ff    <= hdiff_in;
      acc_ff      <= acc_in;
      pl_ff       <= pl_in;
      pr_ff       <= pr_in;
      mean_ff     <= mean_in;
      turn_ff     <= turn_in;
      turnc_ff    <= turnc_in;
      res_pl_ff   <= res_pl_in;
      res_pr_ff   <= res_pr_in;
      res_done_ff <= res_done_in;
      res_ok_ff   <= res_ok_in;
      out_pl_ff   <= out_pl_in;
      out_pr_ff   <= out_pr_in;
      out_done_ff <= out_done_in;
      out_ok_ff   <= out_ok_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.power_left  = out_pl_ff;
   assign rsp_chan.power_right = out_pr_ff;
   assign rsp_chan.done_res    = out_done_ff;
   assign rsp_chan.success     = out_ok_ff;

   // ---------------- assertions ----------------
   a_success_done: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.success |-> rsp_chan.done_res)
      else $error("success without done");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |->
         rsp_chan.power_left == 8'sd0 && rsp_chan.power_right == 8'sd0)
      else $error("power not zero on move end");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && (done_ok || done_fail) |=> !move_active_ff)
      else $error("move still active after end");

   a_power_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.power_left >= -8'sd98 && rsp_chan.power_left <= 8'sd98
         && rsp_chan.power_right >= -8'sd98 && rsp_chan.power_right <= 8'sd98)
      else $error("power out of range");

endmodule
